/* rtl/core/pwvm_pkg.sv */
// Shared constants, types and register codes of the polyphonic wavetable voice mixer.
`timescale 1ns / 1ps

package pwvm_pkg;

	// Sizes of the voice set and the two sample memories
	localparam int VOICES     = 8;
	localparam int WAVE_DEPTH = 4096;
	localparam int ENV_DEPTH  = 256;

	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int WAVE_AW = $clog2(WAVE_DEPTH);
	localparam int ENV_AW  = $clog2(ENV_DEPTH);

	// Field widths
	localparam int OP_W    = 3;
	localparam int INC_W   = 16;
	localparam int ADDR_W  = 12;
	localparam int SAMP_W  = 16;
	localparam int LEVEL_W = 8;
	localparam int EIDX_W  = 8;
	localparam int POS_W   = 20;
	localparam int PINT_W  = 12;
	localparam int FRAC_W  = 8;
	localparam int LEN_W   = 13;
	localparam int ELEN_W  = 9;
	localparam int MIX_W   = 19;
	localparam int PROD_W  = SAMP_W + LEVEL_W + 1;
	localparam int SCL_W   = PROD_W - FRAC_W;
	localparam int ACC_W   = MIX_W + 1;
	localparam int CFG_IW  = 2;

	// Rounding bias for truncation toward zero of a negative product
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(8'hFF);

	localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(262143);
	localparam logic signed [ACC_W-1:0] MIX_MIN = -ACC_W'(262144);

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON   = 3'd0,
		OP_SAMPLE    = 3'd1,
		OP_ENV_TICK  = 3'd2,
		OP_WRITE_WAV = 3'd3,
		OP_WRITE_ENV = 3'd4
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		CFG_WAVE_LEN   = 2'd0,
		CFG_LOOP_LEN   = 2'd1,
		CFG_ATTACK_LEN = 2'd2,
		CFG_ENV_LEN    = 2'd3
	} cfg_idx_t;

	// One voice entry
	typedef struct packed {
		logic [INC_W-1:0]   inc;
		logic [POS_W-1:0]   pos;
		logic [LEVEL_W-1:0] level;
		logic [EIDX_W-1:0]  eidx;
	} voice_t;

	// Write port of the voice memory
	typedef struct packed {
		logic              en;
		logic [VIDX_W-1:0] addr;
		voice_t            data;
	} voice_wr_t;

endpackage

/* rtl/core/polyphonic_wavetable_voice_mixer.sv */
// Top level: command decode, voice walk sequencer, mixing pipeline and output register.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall) takes one command word: note on, sample tick,
//   envelope tick, wave write or envelope write. Output channel (out_valid / out_stall)
//   delivers one mix_sample word per sample tick and nothing for the other commands.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready; the
//   user must write it only while the block is idle, which the block does not enforce.
//   Wave and envelope writes are taken without leaving idle; note on does a read-modify-write
//   of the voice entry; sample and envelope ticks walk the voices: the walk reads one
//   voice entry per cycle from the voice memory, then drains a four-stage pipeline
//   (voice read, wave or envelope read, multiply, accumulate). A sample tick's word
//   enters the output register once the drain completes and that register is free.
//   in_stall is high while a command is in progress; a finished word sits in the
//   output register, so new commands are taken while it waits. If the receiver still
//   stalls an earlier word when the next sample tick finishes, the walk holds until
//   the output register frees.
//   Reset clears the voice entries, the round-robin pointer and the registers to
//   their defaults; wave and envelope memories hold garbage until written.
module polyphonic_wavetable_voice_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pwvm_pkg::OP_W-1:0]         op,
	input  logic [pwvm_pkg::INC_W-1:0]        pitch_increment,
	input  logic [pwvm_pkg::ADDR_W-1:0]       address,
	input  logic signed [pwvm_pkg::SAMP_W-1:0] write_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pwvm_pkg::MIX_W-1:0] mix_sample,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pwvm_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [pwvm_pkg::LEN_W-1:0]        cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NOTE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t                           state_q;
	logic [pwvm_pkg::VIDX_W-1:0]      cnt_q;
	logic [pwvm_pkg::VIDX_W-1:0]      next_voice_q;
	logic                             samp_q;
	logic [pwvm_pkg::INC_W-1:0]       pitch_q;
	logic                             out_valid_q;
	logic signed [pwvm_pkg::MIX_W-1:0] mix_q;

	logic [pwvm_pkg::LEN_W-1:0]  wave_len_q;
	logic [pwvm_pkg::LEN_W-1:0]  loop_len_q;
	logic [pwvm_pkg::LEN_W-1:0]  attack_len_q;
	logic [pwvm_pkg::ELEN_W-1:0] env_len_q;

	logic                        in_acc;
	logic                        pipe_empty;
	logic                        out_free;
	logic                        wave_we;
	logic                        env_we;

	pwvm_pkg::voice_wr_t               vwr;
	pwvm_pkg::voice_t                  vrd;
	logic [pwvm_pkg::VIDX_W-1:0]       vrd_addr;
	logic signed [pwvm_pkg::SAMP_W-1:0] wave_rd;
	logic [pwvm_pkg::LEVEL_W-1:0]      env_rd;

	// Pipeline registers
	logic                              v_s1, v_s2, v_s3;
	logic [pwvm_pkg::VIDX_W-1:0]       vid_s1, vid_s2;
	pwvm_pkg::voice_t                  vdat_s2;
	logic                              hit_s2;
	logic signed [pwvm_pkg::PROD_W-1:0] prod_s3;
	logic signed [pwvm_pkg::ACC_W-1:0] acc_q;

	// Combinational values of stage 1, stage 3 and the clamp
	logic [pwvm_pkg::POS_W:0]          np_s1;
	logic [pwvm_pkg::PINT_W-1:0]       ip_s1;
	logic [pwvm_pkg::PINT_W-1:0]       ipw_s1;
	logic                              hit_s1;
	logic [pwvm_pkg::ELEN_W-1:0]       eidx_nxt_s1;
	logic signed [pwvm_pkg::SCL_W-1:0] scl_s3;
	logic [pwvm_pkg::PROD_W-1:0]       prod_adj_s3;
	logic signed [pwvm_pkg::ACC_W-1:0] mix_sat;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign mix_sample = mix_q;
	assign pipe_empty = !(v_s1 || v_s2 || v_s3);
	assign out_free   = !out_valid_q || !out_stall;

	assign wave_we = in_acc && (op == pwvm_pkg::OP_WRITE_WAV)
		&& ({20'd0, address} < 32'(pwvm_pkg::WAVE_DEPTH));
	assign env_we  = in_acc && (op == pwvm_pkg::OP_WRITE_ENV)
		&& ({20'd0, address} < 32'(pwvm_pkg::ENV_DEPTH));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_len_q   <= pwvm_pkg::LEN_W'(4096);
			loop_len_q   <= pwvm_pkg::LEN_W'(4096);
			attack_len_q <= '0;
			env_len_q    <= pwvm_pkg::ELEN_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pwvm_pkg::CFG_WAVE_LEN:   wave_len_q   <= cfg_data;
				pwvm_pkg::CFG_LOOP_LEN:   loop_len_q   <= cfg_data;
				pwvm_pkg::CFG_ATTACK_LEN: attack_len_q <= cfg_data;
				pwvm_pkg::CFG_ENV_LEN:    env_len_q    <= cfg_data[pwvm_pkg::ELEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Memories
	pwvm_voice_ram u_voice_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (vwr),
		.rd_addr (vrd_addr),
		.rd_data (vrd)
	);

	pwvm_ram #(
		.DEPTH (pwvm_pkg::WAVE_DEPTH),
		.WIDTH (pwvm_pkg::SAMP_W)
	) u_wave_ram (
		.clk     (clk),
		.wr_en   (wave_we),
		.wr_addr (address[pwvm_pkg::WAVE_AW-1:0]),
		.wr_data (write_value),
		.rd_addr (vrd.pos[pwvm_pkg::POS_W-1 -: pwvm_pkg::WAVE_AW]),
		.rd_data (wave_rd)
	);

	pwvm_ram #(
		.DEPTH (pwvm_pkg::ENV_DEPTH),
		.WIDTH (pwvm_pkg::LEVEL_W)
	) u_env_ram (
		.clk     (clk),
		.wr_en   (env_we),
		.wr_addr (address[pwvm_pkg::ENV_AW-1:0]),
		.wr_data (write_value[pwvm_pkg::LEVEL_W-1:0]),
		.rd_addr (vrd.eidx[pwvm_pkg::ENV_AW-1:0]),
		.rd_data (env_rd)
	);

	// Read the walk counter during a walk, the round-robin voice otherwise (as a note on needs)
	assign vrd_addr = (state_q == ST_WALK) ? cnt_q : next_voice_q;

	// Stage 1: advance position with loop, check envelope step
	always_comb begin
		np_s1       = {1'b0, vrd.pos} + {5'd0, vrd.inc};
		ip_s1       = np_s1[pwvm_pkg::POS_W-1:pwvm_pkg::FRAC_W];
		ipw_s1      = ip_s1;
		if ({1'b0, ip_s1} >= wave_len_q) begin
			ipw_s1 = ip_s1 - loop_len_q[pwvm_pkg::PINT_W-1:0];
		end
		eidx_nxt_s1 = {1'b0, vrd.eidx} + pwvm_pkg::ELEN_W'(1);
		hit_s1      = ({1'b0, vrd.pos[pwvm_pkg::POS_W-1:pwvm_pkg::FRAC_W]} >= attack_len_q)
			&& (eidx_nxt_s1 < env_len_q);
	end

	// Voice write: note on, sample advance at stage 1, envelope step at stage 2
	always_comb begin
		vwr = '0;
		if (state_q == ST_NOTE) begin
			vwr.en         = 1'b1;
			vwr.addr       = next_voice_q;
			vwr.data.inc   = pitch_q;
			vwr.data.pos   = '0;
			vwr.data.level = vrd.level;
			vwr.data.eidx  = '0;
		end else if (v_s1 && samp_q) begin
			vwr.en       = 1'b1;
			vwr.addr     = vid_s1;
			vwr.data     = vrd;
			vwr.data.pos = {ipw_s1, np_s1[pwvm_pkg::FRAC_W-1:0]};
		end else if (v_s2 && !samp_q && hit_s2) begin
			vwr.en         = 1'b1;
			vwr.addr       = vid_s2;
			vwr.data       = vdat_s2;
			vwr.data.level = env_rd;
			vwr.data.eidx  = vdat_s2.eidx + pwvm_pkg::EIDX_W'(1);
		end
	end

	// Stage 3: scale by level / 256 truncating toward zero
	always_comb begin
		prod_adj_s3 = prod_s3[pwvm_pkg::PROD_W-1]
			? (prod_s3 + pwvm_pkg::ROUND_BIAS) : prod_s3;
		scl_s3      = pwvm_pkg::SCL_W'($signed(prod_adj_s3) >>> pwvm_pkg::FRAC_W);
	end

	// Clamp the finished sum
	always_comb begin
		mix_sat = acc_q;
		if (acc_q > pwvm_pkg::MIX_MAX) begin
			mix_sat = pwvm_pkg::MIX_MAX;
		end else if (acc_q < pwvm_pkg::MIX_MIN) begin
			mix_sat = pwvm_pkg::MIX_MIN;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_WALK);
			v_s2 <= v_s1;
			v_s3 <= v_s2 && samp_q;
		end
	end

	// Pipeline payload and accumulator
	always_ff @(posedge clk) begin
		vid_s1  <= cnt_q;
		vid_s2  <= vid_s1;
		vdat_s2 <= vrd;
		hit_s2  <= hit_s1;
		prod_s3 <= $signed({1'b0, vdat_s2.level}) * wave_rd;
		if (in_acc && (op == pwvm_pkg::OP_SAMPLE)) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + pwvm_pkg::ACC_W'(scl_s3);
		end
	end

	// Sequencer, round-robin pointer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			next_voice_q <= '0;
			samp_q       <= 1'b0;
			pitch_q      <= '0;
			out_valid_q  <= 1'b0;
			mix_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pitch_q <= pitch_increment;
						cnt_q   <= '0;
						case (op)
							pwvm_pkg::OP_NOTE_ON: begin
								state_q <= ST_NOTE;
							end
							pwvm_pkg::OP_SAMPLE: begin
								samp_q  <= 1'b1;
								state_q <= ST_WALK;
							end
							pwvm_pkg::OP_ENV_TICK: begin
								samp_q  <= 1'b0;
								state_q <= ST_WALK;
							end
							default: ;
						endcase
					end
				end
				ST_NOTE: begin
					if (next_voice_q == pwvm_pkg::VIDX_W'(pwvm_pkg::VOICES - 1)) begin
						next_voice_q <= '0;
					end else begin
						next_voice_q <= next_voice_q + pwvm_pkg::VIDX_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					cnt_q <= cnt_q + pwvm_pkg::VIDX_W'(1);
					if (cnt_q == pwvm_pkg::VIDX_W'(pwvm_pkg::VOICES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						if (!samp_q) begin
							state_q <= ST_IDLE;
						end else if (out_free) begin
							out_valid_q <= 1'b1;
							mix_q       <= mix_sat[pwvm_pkg::MIX_W-1:0];
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Voice writes during the walk never hit the entry being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && vwr.en) |-> (vwr.addr != vrd_addr))
		else $error("voice write collides with walk read");

	// Idle means the walk pipeline has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> pipe_empty)
		else $error("pipeline busy while idle");

	// A new output word only comes from the end of a sample walk
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DRAIN && $past(samp_q)))
		else $error("output word without sample walk");

	// The accumulator stage only runs for sample walks
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> samp_q)
		else $error("accumulate during envelope walk");

endmodule

/* rtl/core/pwvm_ram.sv */
// Generic single-port-write, registered-read RAM for wave and envelope samples.
`timescale 1ns / 1ps

module pwvm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/pwvm_voice_ram.sv */
// Voice state memory: one entry per voice, entries read as zero until written.
`timescale 1ns / 1ps

module pwvm_voice_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pwvm_pkg::voice_wr_t       wr,
	input  logic [pwvm_pkg::VIDX_W-1:0] rd_addr,
	output pwvm_pkg::voice_t          rd_data
);

	pwvm_pkg::voice_t             mem [pwvm_pkg::VOICES];
	logic [pwvm_pkg::VOICES-1:0]  valid_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Store the entry and return registered read data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the wavetable voice mixer: memory fill, command table, then random words.
`timescale 1ns / 1ps

module tb_top;
	import pwvm_pkg::*;

	localparam int CLK_PERIOD   = 2;
	localparam int RESET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 3 * (VOICES + 4);
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;

	// Command codes the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	// Receiver stall patterns
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} rx_mode_t;

	// One row of the command table; want is used where typed is set
	typedef struct packed {
		logic [OP_W-1:0]   opc;
		logic [INC_W-1:0]  pinc;
		logic [ADDR_W-1:0] adr;
		logic [SAMP_W-1:0] wv;
		logic              typed;
		logic [MIX_W-1:0]  want;
	} cmd_row_t;

	localparam int CMD_ROWS = 28;
	localparam cmd_row_t CMD_TAB [CMD_ROWS] = '{
		// levels are zero after reset: silence
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b1, 19'd0},
		'{OP_WRITE_WAV, 16'h0000, 12'h000, 16'h7FFF, 1'b0, 19'd0},
		'{OP_WRITE_ENV, 16'h0000, 12'h000, 16'h00FF, 1'b0, 19'd0},
		'{OP_ENV_TICK,  16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0},
		// full level on the largest sample, all voices at entry zero
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b1, 19'd261112},
		'{OP_WRITE_WAV, 16'h0000, 12'h000, 16'h8000, 1'b0, 19'd0},
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b1, 19'(-261120)},
		// minus one scaled by 255/256 truncates to zero
		'{OP_WRITE_WAV, 16'h0000, 12'h000, 16'hFFFF, 1'b0, 19'd0},
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b1, 19'd0},
		// envelope write past the table is dropped; top entry keeps the low byte
		'{OP_WRITE_ENV, 16'h0000, 12'hFFF, 16'h1234, 1'b0, 19'd0},
		'{OP_WRITE_ENV, 16'h0000, 12'h0FF, 16'hA5C3, 1'b0, 19'd0},
		'{OP_WRITE_WAV, 16'h0000, 12'hFFF, 16'h4000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'hFFFF, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h0100, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_ENV_TICK,  16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0},
		// unused codes with every field bit set
		'{OP_SPARE_5,   16'hFFFF, 12'hFFF, 16'hFFFF, 1'b0, 19'd0},
		'{OP_SPARE_6,   16'hFFFF, 12'hFFF, 16'hFFFF, 1'b0, 19'd0},
		'{OP_SPARE_7,   16'hFFFF, 12'hFFF, 16'hFFFF, 1'b0, 19'd0},
		// fill the rest of the voices and wrap the round robin
		'{OP_NOTE_ON,   16'h0080, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h1234, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h00FF, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h0001, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h8000, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_NOTE_ON,   16'h0300, 12'h000, 16'h0000, 1'b0, 19'd0},
		'{OP_SAMPLE,    16'h0000, 12'h000, 16'h0000, 1'b0, 19'd0}
	};

	// Block ports
	logic                     clk             = 1'b0;
	logic                     arst_n          = 1'b0;
	logic                     in_valid        = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          op              = '0;
	logic [INC_W-1:0]         pitch_increment = '0;
	logic [ADDR_W-1:0]        address         = '0;
	logic signed [SAMP_W-1:0] write_value     = '0;
	logic                     out_valid;
	logic                     out_stall       = 1'b0;
	logic signed [MIX_W-1:0]  mix_sample;
	logic                     cfg_valid       = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IW-1:0]        cfg_index       = '0;
	logic [LEN_W-1:0]         cfg_data        = '0;

	// Predicted voice state, memories and registers
	logic [INC_W-1:0]         v_inc   [VOICES];
	logic [POS_W-1:0]         v_pos   [VOICES];
	logic [LEVEL_W-1:0]       v_level [VOICES];
	logic [EIDX_W-1:0]        v_eidx  [VOICES];
	int unsigned              nxt_voice;
	logic signed [SAMP_W-1:0] wave_mem [WAVE_DEPTH];
	logic [LEVEL_W-1:0]       env_mem  [ENV_DEPTH];
	logic [LEN_W-1:0]         r_wave_len   = LEN_W'(4096);
	logic [LEN_W-1:0]         r_loop_len   = LEN_W'(4096);
	logic [LEN_W-1:0]         r_attack_len = '0;
	logic [ELEN_W-1:0]        r_env_len    = ELEN_W'(256);

	// Mix samples still owed by the block, oldest first
	logic signed [MIX_W-1:0]  pending_mix [$];
	logic signed [MIX_W-1:0]  mix_want;

	int       n_errors     = 0;
	int       n_words      = 0;
	int       n_mix_seen   = 0;
	int       n_reg_writes = 0;
	int       idle_cycles  = 0;
	bit       gappy        = 1'b1;
	int       burst_left   = 0;
	bit       hold_req     = 1'b0;
	bit       hold_done    = 1'b0;
	int       hold_left    = 0;
	rx_mode_t rx_mode      = RX_FREE;
	int       mode_left    = 0;
	int       rx_phase     = 0;

	polyphonic_wavetable_voice_mixer u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.pitch_increment (pitch_increment),
		.address         (address),
		.write_value     (write_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mix_sample      (mix_sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one command word to the predicted state; return 1 with the mix on a sample tick
	function automatic bit step_voices(input logic [OP_W-1:0] opc, input logic [INC_W-1:0] pinc,
			input logic [ADDR_W-1:0] adr, input logic signed [SAMP_W-1:0] wv,
			output logic signed [MIX_W-1:0] mix);
		int acc;
		int scaled;
		logic [POS_W-1:0]  np;
		logic [PINT_W-1:0] ip;
		mix = '0;
		step_voices = 1'b0;
		case (opc)
			OP_NOTE_ON: begin
				v_inc[nxt_voice]  = pinc;
				v_pos[nxt_voice]  = '0;
				v_eidx[nxt_voice] = '0;
				nxt_voice = (nxt_voice + 1) % VOICES;
			end
			OP_SAMPLE: begin
				acc = 0;
				for (int v = 0; v < VOICES; v++) begin
					scaled = (int'(v_level[v]) * int'(wave_mem[v_pos[v][POS_W-1:FRAC_W]])) / 256;
					acc += scaled;
					// advance, then step back by the loop once past the wave end
					np = v_pos[v] + POS_W'(v_inc[v]);
					ip = np[POS_W-1:FRAC_W];
					if (ip >= r_wave_len)
						ip = ip - r_loop_len[PINT_W-1:0];
					v_pos[v] = {ip, np[FRAC_W-1:0]};
				end
				if (acc > 262143)
					acc = 262143;
				if (acc < -262144)
					acc = -262144;
				mix = MIX_W'(acc);
				step_voices = 1'b1;
			end
			OP_ENV_TICK: begin
				for (int v = 0; v < VOICES; v++) begin
					if (v_pos[v][POS_W-1:FRAC_W] >= r_attack_len &&
							int'(v_eidx[v]) + 1 < int'(r_env_len)) begin
						v_level[v] = env_mem[v_eidx[v]];
						v_eidx[v]  = v_eidx[v] + 1'b1;
					end
				end
			end
			OP_WRITE_WAV: begin
				if (adr < WAVE_DEPTH)
					wave_mem[adr] = wv;
			end
			OP_WRITE_ENV: begin
				if (adr < ENV_DEPTH)
					env_mem[adr] = wv[LEVEL_W-1:0];
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic signed [MIX_W-1:0] want,
			input logic signed [MIX_W-1:0] got);
		n_errors++;
		$display("ERROR at %0t: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Offer one command word; in gappy mode, with a random gap whenever a burst runs out
	task automatic send_word(input logic [OP_W-1:0] opc, input logic [INC_W-1:0] pinc,
			input logic [ADDR_W-1:0] adr, input logic [SAMP_W-1:0] wv,
			input logic typed, input logic [MIX_W-1:0] want);
		logic signed [MIX_W-1:0] mix;
		int gap;
		if (gappy) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 16);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		op              <= opc;
		pitch_increment <= pinc;
		address         <= adr;
		write_value     <= wv;
		in_valid        <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_words++;
		if (step_voices(opc, pinc, adr, wv, mix))
			pending_mix.push_back(typed ? want : mix);
	endtask

	// Pick a random command; unused codes do not count toward the phase
	task automatic random_word(output bit counted);
		int pick;
		logic [OP_W-1:0]   opc;
		logic [INC_W-1:0]  pinc;
		logic [ADDR_W-1:0] adr;
		pick = $urandom_range(0, 99);
		pinc = ($urandom_range(0, 1) != 0) ? INC_W'($urandom_range(0, 2047)) : INC_W'($urandom);
		adr = ADDR_W'($urandom);
		counted = 1'b1;
		if (pick < 34)
			opc = OP_SAMPLE;
		else if (pick < 50)
			opc = OP_ENV_TICK;
		else if (pick < 66)
			opc = OP_NOTE_ON;
		else if (pick < 84)
			opc = OP_WRITE_WAV;
		else if (pick < 97) begin
			opc = OP_WRITE_ENV;
			if ($urandom_range(0, 3) != 0)
				adr = ADDR_W'($urandom_range(0, ENV_DEPTH - 1));
		end else begin
			opc = OP_W'($urandom_range(int'(OP_WRITE_ENV) + 1, (1 << OP_W) - 1));
			counted = 1'b0;
		end
		send_word(opc, pinc, adr, SAMP_W'($urandom), 1'b0, '0);
	endtask

	task automatic run_random(input int count);
		int done;
		bit counted;
		done = 0;
		while (done < count) begin
			random_word(counted);
			if (counted)
				done++;
		end
	endtask

	// Drop valid, wait for every owed sample, then let the last walk finish
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WAVE_LEN:   r_wave_len   = val;
			CFG_LOOP_LEN:   r_loop_len   = val;
			CFG_ATTACK_LEN: r_attack_len = val;
			default:        r_env_len    = val[ELEN_W-1:0];
		endcase
		n_reg_writes++;
	endtask

	task automatic load_regs(input int wl, input int ll, input int al, input int el);
		write_reg(CFG_WAVE_LEN, LEN_W'(wl));
		write_reg(CFG_LOOP_LEN, LEN_W'(ll));
		write_reg(CFG_ATTACK_LEN, LEN_W'(al));
		write_reg(CFG_ENV_LEN, LEN_W'(el));
		cfg_valid <= 1'b0;
	endtask

	// Receiver: one long hold when asked, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end else
				mode_left--;
			rx_phase = (rx_phase + 1) % 7;
			case (rx_mode)
				RX_FREE:     out_stall <= 1'b0;
				RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: out_stall <= (rx_phase < 3);
				default:     out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Check each delivered word against the oldest owed sample
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_mix_seen++;
			if (pending_mix.size() == 0)
				report_mismatch("mix word with nothing owed", '0, mix_sample);
			else begin
				mix_want = pending_mix.pop_front();
				if (mix_sample !== mix_want)
					report_mismatch("mix_sample", mix_want, mix_sample);
			end
		end
	end

	// Watchdog: end the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (idle_cycles == IDLE_LIMIT) begin
			$display("Timeout at %0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("** polyphonic_wavetable_voice_mixer: FAILED **");
			$finish;
		end else
			idle_cycles++;
	end

	initial begin
		for (int v = 0; v < VOICES; v++) begin
			v_inc[v]   = '0;
			v_pos[v]   = '0;
			v_level[v] = '0;
			v_eidx[v]  = '0;
		end
		nxt_voice = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both memories so no walk reads an unwritten entry
		for (int i = 0; i < WAVE_DEPTH; i++)
			send_word(OP_WRITE_WAV, INC_W'($urandom), ADDR_W'(i), SAMP_W'($urandom), 1'b0, '0);
		for (int i = 0; i < ENV_DEPTH; i++)
			send_word(OP_WRITE_ENV, INC_W'($urandom), ADDR_W'(i), SAMP_W'($urandom), 1'b0, '0);

		// Walk the command table
		for (int i = 0; i < CMD_ROWS; i++)
			send_word(CMD_TAB[i].opc, CMD_TAB[i].pinc, CMD_TAB[i].adr, CMD_TAB[i].wv,
				CMD_TAB[i].typed, CMD_TAB[i].want);

		// Random phases under several register settings
		run_random(150);
		settle();
		gappy = 1'b0;
		load_regs(1, 1, 0, 1);
		run_random(140);

		settle();
		gappy = 1'b1;
		load_regs(64, 32, 4, 16);
		hold_req = 1'b1;
		run_random(160);

		settle();
		gappy = 1'b0;
		load_regs(4096, 1, 4096, 2);
		run_random(140);

		settle();
		gappy = 1'b1;
		load_regs(300, 4096, 100, 256);
		run_random(160);

		settle();
		load_regs($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 4096),
			$urandom_range(1, 256));
		run_random(120);

		settle();
		gappy = 1'b0;
		load_regs(4096, 4096, 0, 256);
		run_random(80);
		settle();

		$display("Covered %0d command words and %0d register writes over seven settings;",
			n_words, n_reg_writes);
		$display("%0d mix samples checked, %0d mismatches.", n_mix_seen, n_errors);
		if (n_errors == 0 && pending_mix.size() == 0)
			$display("** polyphonic_wavetable_voice_mixer: PASSED **");
		else
			$display("** polyphonic_wavetable_voice_mixer: FAILED **");
		$finish;
	end

endmodule
